[rtl/core/grwc_pkg.sv]
// Shared types, constants and trig tables for the grid ray caster.
// No dependencies; used by every module of the block.
`default_nettype none
package grwc_pkg;

	localparam int CW     = 29;  // ray coordinate, 1/16 px, signed
	localparam int DW     = 47;  // raw distance, Q14
	localparam int AW     = 16;  // march axis coordinate
	localparam int SLW    = 25;  // tan/cot slope, Q14
	localparam int PW     = 42;  // march product
	localparam int DIV_NW = 36;  // divider numerator and quotient
	localparam int DIV_DW = 50;  // divider denominator

	typedef struct packed {
		logic [12:0] player_x;
		logic [12:0] player_y;
		logic [8:0]  player_angle;
	} request_t;

	typedef struct packed {
		logic [5:0]         column;
		logic [8:0]         wall_height;
		logic [7:0]         wall_top;
		logic               vertical_hit;
		logic signed [15:0] hit_x;
		logic signed [15:0] hit_y;
		logic               last_column;
	} result_t;

	typedef enum logic [4:0] {
		CMD_NONE, CMD_LOAD, CMD_TRIG, CMD_DIV_V, CMD_SETUP_V, CMD_DIV_H, CMD_SETUP_H,
		CMD_MUL, CMD_TEST, CMD_DVA, CMD_DVB, CMD_DHA, CMD_DHB, CMD_SEL, CMD_CLO,
		CMD_CHI, CMD_CRND, CMD_DIV_HT, CMD_EMIT
	} cmd_t;

	typedef enum logic [4:0] {
		S_IDLE, S_TRIG, S_VCHK, S_VDIV, S_HCHK, S_HDIV, S_MUL, S_TEST, S_DVA, S_DVB,
		S_DHA, S_DHB, S_SEL, S_CLO, S_CHI, S_CRND, S_HCK, S_HTDIV, S_EMIT
	} state_t;

	typedef struct packed {
		logic skip_v;
		logic skip_h;
		logic step_end;
		logic march_h;
		logic div_done;
		logic any_hit;
		logic corr_pos;
		logic last_ray;
	} status_t;

	localparam logic [14:0] QSINE [91] = '{
		15'd0, 15'd286, 15'd572, 15'd857, 15'd1143, 15'd1428, 15'd1713, 15'd1997,
		15'd2280, 15'd2563, 15'd2845, 15'd3126, 15'd3406, 15'd3686, 15'd3964, 15'd4240,
		15'd4516, 15'd4790, 15'd5063, 15'd5334, 15'd5604, 15'd5872, 15'd6138, 15'd6402,
		15'd6664, 15'd6924, 15'd7182, 15'd7438, 15'd7692, 15'd7943, 15'd8192, 15'd8438,
		15'd8682, 15'd8923, 15'd9162, 15'd9397, 15'd9630, 15'd9860, 15'd10087, 15'd10311,
		15'd10531, 15'd10749, 15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786,
		15'd11982, 15'd12176, 15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085,
		15'd13255, 15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189,
		15'd14330, 15'd14466, 15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082,
		15'd15191, 15'd15296, 15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749,
		15'd15826, 15'd15897, 15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182,
		15'd16225, 15'd16262, 15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374,
		15'd16382, 15'd16384
	};

	// angle in 0..359
	function automatic logic signed [15:0] sin_q(input logic [8:0] a);
		logic [6:0]  idx;
		logic        neg;
		logic [15:0] mag;
		if (a <= 9'd90) begin
			idx = 7'(a); neg = 1'b0;
		end else if (a <= 9'd180) begin
			idx = 7'(9'd180 - a); neg = 1'b0;
		end else if (a <= 9'd270) begin
			idx = 7'(a - 9'd180); neg = 1'b1;
		end else begin
			idx = 7'(9'd360 - a); neg = 1'b1;
		end
		mag = {1'b0, QSINE[idx]};
		return neg ? -$signed(mag) : $signed(mag);
	endfunction

	function automatic logic signed [15:0] cos_q(input logic [8:0] a);
		return sin_q((a >= 9'd270) ? a - 9'd270 : a + 9'd90);
	endfunction

endpackage
`default_nettype wire

[rtl/core/grwc_div.sv]
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on grwc_pkg for widths.
`default_nettype none
module grwc_div import grwc_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [DIV_NW-1:0] num,
	input  wire logic [DIV_DW-1:0] den,
	output logic                   done,
	output logic [DIV_NW-1:0]      quo
);
	localparam int CNT_W = $clog2(DIV_NW + 1);

	logic              run_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIV_DW:0]   rem_q;
	logic [DIV_NW-1:0] quo_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_DW:0]   trial;
	logic              fits;

	assign trial = {rem_q[DIV_DW-1:0], quo_q[DIV_NW-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_NW - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (run_q) begin
			rem_q <= fits ? trial - {1'b0, den_q} : trial;
			quo_q <= {quo_q[DIV_NW-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule
`default_nettype wire

[rtl/core/grwc_dpath.sv]
// Ray caster datapath: frame and ray registers, march unit, distance
// multiplier, fisheye correction and result register. Uses grwc_pkg, grwc_div.
`default_nettype none
module grwc_dpath import grwc_pkg::*; #(
	parameter int MAP_W       = 8,
	parameter int MAP_H       = 8,
	parameter int NUM_RAYS    = 60,
	parameter int MAX_STEPS   = 8,
	parameter int VIEW_HEIGHT = 320
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire cmd_t     cmd,
	input  wire request_t req,
	input  wire logic     cfg_we,
	input  wire logic [63:0] cfg_wdata,
	output status_t       stat,
	output logic          done,
	output result_t       res
);
	localparam int KW   = $clog2(MAX_STEPS + 1);
	localparam int HT_W = $clog2(VIEW_HEIGHT + 1);
	localparam logic [DIV_NW-1:0] HT_NUM = DIV_NW'(64'(VIEW_HEIGHT) << 24);

	logic [63:0]            wall_map_q;
	logic [12:0]            px_q, py_q;
	logic [8:0]             pang_q, ra_q;
	logic [5:0]             col_q;
	logic signed [15:0]     s_q, c_q, cd_q;
	logic signed [SLW-1:0]  slope_q;
	logic signed [AW-1:0]   a_q;
	logic [KW-1:0]          k_q;
	logic                   hsel_q, stepneg_q, neg_q;
	logic signed [PW-1:0]   prod_s1;
	logic signed [CW-1:0]   vx_q, vy_q, hx_q, hy_q, ex_q, ey_q;
	logic                   vhit_q, hhit_q, usev_q;
	logic signed [DW-1:0]   dv_q, dh_q, d_q;
	logic signed [63:0]     acc_q;
	logic signed [DIV_DW-1:0] corr_q;
	logic                   done_q;
	result_t                res_q;

	// march
	logic signed [16:0]     pa0, pb0, diff_w;
	logic signed [PW-1:0]   prod_w;
	logic signed [CW-1:0]   b_w, xs, ys, tx, ty;
	logic                   wall, last_step;
	logic [5:0]             widx;
	always_comb begin
		pa0    = hsel_q ? $signed({4'b0, py_q}) : $signed({4'b0, px_q});
		pb0    = hsel_q ? $signed({4'b0, px_q}) : $signed({4'b0, py_q});
		diff_w = pa0 - 17'(a_q);
		prod_w = diff_w * slope_q;
		b_w    = CW'(pb0) + CW'((prod_s1 + PW'(8192)) >>> 14);
		xs     = hsel_q ? b_w : CW'(a_q);
		ys     = hsel_q ? CW'(a_q) : b_w;
		tx     = xs >>> 10;
		ty     = ys >>> 10;
		widx   = 6'(32'(ty[2:0]) * MAP_W + 32'(tx[2:0]));
		wall   = (tx >= 0) && (tx < CW'(MAP_W)) && (ty >= 0) && (ty < CW'(MAP_H))
			&& wall_map_q[widx];
		last_step = (k_q == KW'(MAX_STEPS));
	end

	// divider operands
	logic [15:0]           abs_s, abs_c, abs_n, abs_d;
	logic                  div_start;
	logic [DIV_NW-1:0]     div_num, div_quo;
	logic [DIV_DW-1:0]     div_den;
	logic                  div_done;
	always_comb begin
		abs_s = s_q[15] ? 16'(-s_q) : 16'(s_q);
		abs_c = c_q[15] ? 16'(-c_q) : 16'(c_q);
		abs_n = (cmd == CMD_DIV_V) ? abs_s : abs_c;
		abs_d = (cmd == CMD_DIV_V) ? abs_c : abs_s;
		div_start = (cmd == CMD_DIV_V) || (cmd == CMD_DIV_H) || (cmd == CMD_DIV_HT);
		if (cmd == CMD_DIV_HT) begin
			div_num = HT_NUM;
			div_den = corr_q;
		end else begin
			div_num = DIV_NW'({abs_n, 14'b0}) + DIV_NW'(abs_d >> 1);
			div_den = DIV_DW'(abs_d);
		end
	end

	grwc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	logic signed [SLW-1:0] slope_w;
	assign slope_w = neg_q ? -$signed(div_quo[SLW-1:0]) : $signed(div_quo[SLW-1:0]);

	// distance multiplier
	logic signed [15:0]   ma;
	logic signed [29:0]   mb;
	logic signed [45:0]   mprod;
	always_comb begin
		ma = ((cmd == CMD_DVA) || (cmd == CMD_DHA)) ? c_q : s_q;
		case (cmd)
			CMD_DVA: mb = 30'(vx_q) - $signed({17'b0, px_q});
			CMD_DVB: mb = 30'(vy_q) - $signed({17'b0, py_q});
			CMD_DHA: mb = 30'(hx_q) - $signed({17'b0, px_q});
			default: mb = 30'(hy_q) - $signed({17'b0, py_q});
		endcase
		mprod = ma * mb;
	end

	// fisheye correction partial products
	logic signed [23:0] lo_w, hi_w;
	logic signed [39:0] plo, phi;
	assign lo_w = $signed({1'b0, d_q[22:0]});
	assign hi_w = $signed(d_q[46:23]);
	assign plo  = lo_w * cd_q;
	assign phi  = hi_w * cd_q;

	// frame angle prep
	logic [8:0]  pang_w, off_w, ra_w;
	logic [9:0]  ra_t;
	always_comb begin
		pang_w = (req.player_angle >= 9'd360) ? req.player_angle - 9'd360 : req.player_angle;
		ra_t   = 10'(pang_w) + 10'(NUM_RAYS / 2);
		ra_w   = (ra_t >= 10'd360) ? 9'(ra_t - 10'd360) : 9'(ra_t);
		off_w  = (pang_q >= ra_q) ? pang_q - ra_q : 9'(10'(pang_q) + 10'd360 - 10'(ra_q));
	end

	// result formatting
	logic [HT_W-1:0]      ht_w, top_w;
	logic signed [CW-1:0] shx, shy;
	logic signed [15:0]   satx, saty;
	always_comb begin
		if (!(vhit_q || hhit_q))
			ht_w = '0;
		else if (corr_q <= 0)
			ht_w = HT_W'(VIEW_HEIGHT);
		else if (div_quo > DIV_NW'(VIEW_HEIGHT))
			ht_w = HT_W'(VIEW_HEIGHT);
		else
			ht_w = HT_W'(div_quo);
		top_w = HT_W'(VIEW_HEIGHT / 2) - (ht_w >> 1);
		shx = ex_q >>> 4;
		shy = ey_q >>> 4;
		satx = (shx > CW'(32767)) ? 16'sd32767 : (shx < -CW'(32768)) ? -16'sd32768 : 16'(shx);
		saty = (shy > CW'(32767)) ? 16'sd32767 : (shy < -CW'(32768)) ? -16'sd32768 : 16'(shy);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wall_map_q <= '0;
			done_q     <= 1'b0;
		end else begin
			if (cfg_we)
				wall_map_q <= cfg_wdata;
			done_q <= (cmd == CMD_EMIT);
		end
	end

	always_ff @(posedge clk) begin
		case (cmd)
			CMD_LOAD: begin
				px_q   <= req.player_x;
				py_q   <= req.player_y;
				pang_q <= pang_w;
				ra_q   <= ra_w;
				col_q  <= '0;
			end
			CMD_TRIG: begin
				s_q    <= sin_q(ra_q);
				c_q    <= cos_q(ra_q);
				cd_q   <= cos_q(off_w);
				vx_q   <= CW'({1'b0, px_q});
				hx_q   <= CW'({1'b0, px_q});
				vy_q   <= CW'({1'b0, py_q});
				hy_q   <= CW'({1'b0, py_q});
				vhit_q <= 1'b0;
				hhit_q <= 1'b0;
			end
			CMD_DIV_V, CMD_DIV_H: neg_q <= s_q[15] ^ c_q[15];
			CMD_SETUP_V: begin
				slope_q   <= slope_w;
				k_q       <= '0;
				hsel_q    <= 1'b0;
				stepneg_q <= !(c_q > 16);
				a_q       <= (c_q > 16) ? $signed({3'b0, px_q[12:10], 10'b0}) + 16'sd1024
					: $signed({3'b0, px_q[12:10], 10'b0}) - 16'sd1;
			end
			CMD_SETUP_H: begin
				slope_q   <= slope_w;
				k_q       <= '0;
				hsel_q    <= 1'b1;
				stepneg_q <= (s_q > 16);
				a_q       <= (s_q > 16) ? $signed({3'b0, py_q[12:10], 10'b0}) - 16'sd1
					: $signed({3'b0, py_q[12:10], 10'b0}) + 16'sd1024;
			end
			CMD_MUL: prod_s1 <= prod_w;
			CMD_TEST: begin
				if (last_step || wall) begin
					if (hsel_q) begin
						hy_q   <= CW'(a_q);
						hx_q   <= b_w;
						hhit_q <= !last_step;
					end else begin
						vx_q   <= CW'(a_q);
						vy_q   <= b_w;
						vhit_q <= !last_step;
					end
				end else begin
					a_q <= stepneg_q ? a_q - 16'sd1024 : a_q + 16'sd1024;
					k_q <= k_q + 1'b1;
				end
			end
			CMD_DVA: dv_q <= DW'(mprod);
			CMD_DVB: dv_q <= dv_q - DW'(mprod);
			CMD_DHA: dh_q <= DW'(mprod);
			CMD_DHB: dh_q <= dh_q - DW'(mprod);
			CMD_SEL: begin
				usev_q <= vhit_q && (!hhit_q || dv_q < dh_q);
				if (vhit_q && (!hhit_q || dv_q < dh_q)) begin
					ex_q <= vx_q; ey_q <= vy_q; d_q <= dv_q;
				end else begin
					ex_q <= hx_q; ey_q <= hy_q; d_q <= dh_q;
				end
			end
			CMD_CLO:  acc_q  <= 64'(plo);
			CMD_CHI:  acc_q  <= acc_q + (64'(phi) <<< 23);
			CMD_CRND: corr_q <= DIV_DW'((acc_q + 64'sd8192) >>> 14);
			CMD_EMIT: begin
				res_q.column       <= col_q;
				res_q.wall_height  <= 9'(ht_w);
				res_q.wall_top     <= 8'(top_w);
				res_q.vertical_hit <= usev_q;
				res_q.hit_x        <= satx;
				res_q.hit_y        <= saty;
				res_q.last_column  <= (col_q == 6'(NUM_RAYS - 1));
				col_q <= col_q + 1'b1;
				ra_q  <= (ra_q == 9'd0) ? 9'd359 : ra_q - 9'd1;
			end
			default: ;
		endcase
	end

	always_comb begin
		stat.skip_v   = !((c_q > 16) || (c_q < -16));
		stat.skip_h   = !((s_q > 16) || (s_q < -16));
		stat.step_end = last_step || wall;
		stat.march_h  = hsel_q;
		stat.div_done = div_done;
		stat.any_hit  = vhit_q || hhit_q;
		stat.corr_pos = corr_q > 0;
		stat.last_ray = (col_q == 6'(NUM_RAYS - 1));
	end

	assign done = done_q;
	assign res  = res_q;
endmodule
`default_nettype wire

[rtl/core/grwc_ctrl.sv]
// Ray caster sequencer: steps each ray through trig, marches, distance,
// correction and height division. Uses grwc_pkg only.
`default_nettype none
module grwc_ctrl import grwc_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	input  wire status_t stat,
	output cmd_t         cmd,
	output logic         busy
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (start) state_d = S_TRIG;
			S_TRIG:  state_d = S_VCHK;
			S_VCHK:  state_d = stat.skip_v ? S_HCHK : S_VDIV;
			S_VDIV:  if (stat.div_done) state_d = S_MUL;
			S_HCHK:  state_d = stat.skip_h ? S_DVA : S_HDIV;
			S_HDIV:  if (stat.div_done) state_d = S_MUL;
			S_MUL:   state_d = S_TEST;
			S_TEST: begin
				if (stat.step_end)
					state_d = stat.march_h ? S_DVA : S_HCHK;
				else
					state_d = S_MUL;
			end
			S_DVA:   state_d = S_DVB;
			S_DVB:   state_d = S_DHA;
			S_DHA:   state_d = S_DHB;
			S_DHB:   state_d = S_SEL;
			S_SEL:   state_d = S_CLO;
			S_CLO:   state_d = S_CHI;
			S_CHI:   state_d = S_CRND;
			S_CRND:  state_d = S_HCK;
			S_HCK:   state_d = (stat.any_hit && stat.corr_pos) ? S_HTDIV : S_EMIT;
			S_HTDIV: if (stat.div_done) state_d = S_EMIT;
			S_EMIT:  state_d = stat.last_ray ? S_IDLE : S_TRIG;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = CMD_NONE;
		case (state_q)
			S_IDLE:  if (start) cmd = CMD_LOAD;
			S_TRIG:  cmd = CMD_TRIG;
			S_VCHK:  if (!stat.skip_v) cmd = CMD_DIV_V;
			S_VDIV:  if (stat.div_done) cmd = CMD_SETUP_V;
			S_HCHK:  if (!stat.skip_h) cmd = CMD_DIV_H;
			S_HDIV:  if (stat.div_done) cmd = CMD_SETUP_H;
			S_MUL:   cmd = CMD_MUL;
			S_TEST:  cmd = CMD_TEST;
			S_DVA:   cmd = CMD_DVA;
			S_DVB:   cmd = CMD_DVB;
			S_DHA:   cmd = CMD_DHA;
			S_DHB:   cmd = CMD_DHB;
			S_SEL:   cmd = CMD_SEL;
			S_CLO:   cmd = CMD_CLO;
			S_CHI:   cmd = CMD_CHI;
			S_CRND:  cmd = CMD_CRND;
			S_HCK:   if (stat.any_hit && stat.corr_pos) cmd = CMD_DIV_HT;
			S_EMIT:  cmd = CMD_EMIT;
			default: cmd = CMD_NONE;
		endcase
	end

	assign busy = (state_q != S_IDLE);
endmodule
`default_nettype wire

[rtl/core/grid_raycast_wall_columns_core.sv]
// Top level of the grid ray caster: sequencer plus datapath.
// Depends on grwc_pkg, grwc_ctrl, grwc_dpath (and grwc_div below it).
//
// Usage: write the 64-bit wall bitmap through cfg_we/cfg_wdata while idle.
// A frame request is taken on a clock edge with start high and busy low;
// req carries player position (1/16 px) and facing angle in degrees.
// The block then casts NUM_RAYS rays, one after another, and presents one
// result per ray on res for exactly one cycle with done high; the last ray
// has res.last_column set. Results cannot be stalled.
// Per ray: control and emit states, a slope division per march (none for a
// march whose axis is skipped), tile tests with up to MAX_STEPS+1 tests per
// march, distance and correction steps, and the height division when a wall
// was hit at positive distance. The divisions share one divider that yields
// one quotient bit per cycle. Busy is already low in the cycle that presents
// the last result.
// Reset clears the wall bitmap to all open tiles and returns to idle.
`default_nettype none
module grid_raycast_wall_columns_core import grwc_pkg::*; #(
	parameter int MAP_W       = 8,
	parameter int MAP_H       = 8,
	parameter int NUM_RAYS    = 60,
	parameter int MAX_STEPS   = 8,
	parameter int VIEW_HEIGHT = 320
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire request_t    req,
	input  wire logic        cfg_we,
	input  wire logic [63:0] cfg_wdata,
	output logic             done,
	output result_t          res
);
	cmd_t    cmd;
	status_t stat;

	grwc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	grwc_dpath #(
		.MAP_W       (MAP_W),
		.MAP_H       (MAP_H),
		.NUM_RAYS    (NUM_RAYS),
		.MAX_STEPS   (MAX_STEPS),
		.VIEW_HEIGHT (VIEW_HEIGHT)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.stat      (stat),
		.done      (done),
		.res       (res)
	);

	a_done_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without active frame");

	a_done_spaced: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("results in adjacent cycles");

	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		done && res.last_column |-> !busy)
		else $error("still busy after final column");
endmodule
`default_nettype wire

[bench/testbench.sv]
// Self-checking bench for grid_raycast_wall_columns_core: frame requests over
// directed and random wall maps, each column checked against a local ray caster.
// Depends on grwc_pkg and the core RTL.
`default_nettype none
module testbench;
	import grwc_pkg::*;

	localparam int NRAYS = 60;
	localparam int STEPS = 8;
	localparam int VIEWH = 320;
	localparam int NDIR = 12;
	localparam int NRAND = 240;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	request_t req = '0;
	logic cfg_we = 1'b0;
	logic [63:0] cfg_wdata = '0;
	logic done;
	result_t res;

	logic [63:0] wall_bits = '0;
	result_t column_q[$];
	int mismatches = 0;
	int frames = 0;
	int columns_seen = 0;
	int full_height = 0;
	int empty_rays = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	grid_raycast_wall_columns_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done), .res(res)
	);

	function automatic longint trig_sin(input int unsigned a);
		a = a % 360;
		if (a <= 90) return longint'(QSINE[a]);
		if (a <= 180) return longint'(QSINE[180 - a]);
		if (a <= 270) return -longint'(QSINE[a - 180]);
		return -longint'(QSINE[360 - a]);
	endfunction

	function automatic longint trig_cos(input int unsigned a);
		return trig_sin((a % 360) + 90);
	endfunction

	function automatic longint rnd14(input longint v);
		return (v + 8192) >>> 14;
	endfunction

	function automatic longint quot_round(input longint n, input longint d);
		longint an, ad, q;
		an = n < 0 ? -n : n;
		ad = d < 0 ? -d : d;
		q = (an + ad / 2) / ad;
		return ((n < 0) != (d < 0)) ? -q : q;
	endfunction

	function automatic bit tile_solid(input longint x, input longint y);
		longint tx, ty;
		tx = x >>> 10;
		ty = y >>> 10;
		if (tx < 0 || tx >= 8 || ty < 0 || ty >= 8) return 1'b0;
		return wall_bits[ty * 8 + tx];
	endfunction

	task automatic grid_march(input longint pa, input longint pb, input longint a0,
			input longint stp, input longint slope, input bit swap,
			output longint ea, output longint eb, output bit hit);
		longint a, b;
		a = a0;
		b = pb + rnd14((pa - a0) * slope);
		hit = 1'b0;
		for (int k = 0; k < STEPS && !hit; k++) begin
			if (swap ? tile_solid(b, a) : tile_solid(a, b)) hit = 1'b1;
			else begin
				a += stp;
				b = pb + rnd14((pa - a) * slope);
			end
		end
		ea = a;
		eb = b;
	endtask

	function automatic logic signed [15:0] px_sat(input longint v);
		v = v >>> 4;
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return 16'(v);
	endfunction

	task automatic cast_frame(input request_t r);
		longint px, py, s, c, vx, vy, hx, hy, dv, dh, d, ex, ey, corr, h, slope, x0;
		int unsigned pang, ra;
		bit vh, hh, use_v;
		result_t o;
		px = r.player_x;
		py = r.player_y;
		pang = r.player_angle % 360;
		ra = (pang + NRAYS / 2) % 360;
		for (int k = 0; k < NRAYS; k++) begin
			s = trig_sin(ra);
			c = trig_cos(ra);
			vx = px; vy = py; hx = px; hy = py; dv = 0; dh = 0;
			vh = 1'b0; hh = 1'b0;
			if (c > 16 || c < -16) begin
				slope = quot_round(s * 16384, c);
				x0 = c > 16 ? ((px >>> 10) << 10) + 1024 : ((px >>> 10) << 10) - 1;
				grid_march(px, py, x0, c > 16 ? 1024 : -1024, slope, 1'b0, vx, vy, vh);
				if (vh) dv = c * (vx - px) - s * (vy - py);
			end
			if (s > 16 || s < -16) begin
				slope = quot_round(c * 16384, s);
				x0 = s > 16 ? ((py >>> 10) << 10) - 1 : ((py >>> 10) << 10) + 1024;
				grid_march(py, px, x0, s > 16 ? -1024 : 1024, slope, 1'b1, hy, hx, hh);
				if (hh) dh = c * (hx - px) - s * (hy - py);
			end
			use_v = vh && (!hh || dv < dh);
			ex = use_v ? vx : hx;
			ey = use_v ? vy : hy;
			d = use_v ? dv : dh;
			h = 0;
			if (vh || hh) begin
				corr = rnd14(d * trig_cos(pang + 360 - ra));
				if (corr <= 0) h = VIEWH;
				else begin
					h = (longint'(64) * 16 * 16384 * VIEWH) / corr;
					if (h > VIEWH) h = VIEWH;
				end
			end
			o.column = 6'(k);
			o.wall_height = 9'(h);
			o.wall_top = 8'(VIEWH / 2 - h / 2);
			o.vertical_hit = use_v;
			o.hit_x = px_sat(ex);
			o.hit_y = px_sat(ey);
			o.last_column = (k == NRAYS - 1);
			column_q.push_back(o);
			ra = (ra + 359) % 360;
		end
	endtask

	always @(posedge clk) begin
		if (done) begin
			columns_seen++;
			if (column_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected column %0d", res.column);
			end else begin
				if (res !== column_q[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("column mismatch: exp %p got %p", column_q[0], res);
				end
				if (res.wall_height == VIEWH) full_height++;
				if (res.wall_height == 0) empty_rays++;
				void'(column_q.pop_front());
			end
		end
	end

	task automatic load_map(input logic [63:0] m);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		wall_bits = m;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain;
		while (column_q.size() != 0 || busy) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// returns at the accepting edge; start stays high, which is harmless while busy
	task automatic issue(input request_t r, input bit no_gaps);
		if (!no_gaps) while ($urandom_range(99) < 27) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
		cast_frame(r);
		frames++;
	endtask

	// directed frames; wall_height typed in where obvious, else -1
	typedef struct {
		logic [63:0] map;
		logic [12:0] x;
		logic [12:0] y;
		logic [8:0]  ang;
		int          h0;
	} dir_row_t;

	dir_row_t dir_rows[NDIR] = '{
		'{64'h0, 13'd0, 13'd0, 9'd0, 0},
		'{64'hFFFF_FFFF_FFFF_FFFF, 13'd8191, 13'd8191, 9'd359, -1},
		'{64'hFFFF_FFFF_FFFF_FFFF, 13'd4608, 13'd4608, 9'd90, -1},
		'{64'hFF81_8181_8181_81FF, 13'd4096, 13'd4096, 9'd0, -1},
		'{64'hFF81_8181_8181_81FF, 13'd1100, 13'd1100, 9'd180, -1},
		'{64'hFF81_8181_8181_81FF, 13'd2048, 13'd6000, 9'd270, -1},
		'{64'h0000_0000_0000_0001, 13'd1500, 13'd1500, 9'd225, -1},
		'{64'h8000_0000_0000_0000, 13'd100, 13'd100, 9'd315, -1},
		'{64'h0000_0000_0000_0001, 13'd512, 13'd512, 9'd45, 0},
		'{64'hFF81_8181_8181_81FF, 13'd4096, 13'd4096, 9'd511, -1},
		'{64'h0, 13'd8191, 13'd0, 9'd135, 0},
		'{64'hAAAA_5555_AAAA_5555, 13'd2900, 13'd3700, 9'd30, -1}
	};

	logic [63:0] rand_map;
	request_t r;
	int n_open;

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		for (int i = 0; i < NDIR; i++) begin
			if (i == 0 || dir_rows[i].map != wall_bits) begin
				start <= 1'b0;
				drain();
				load_map(dir_rows[i].map);
			end
			r.player_x = dir_rows[i].x;
			r.player_y = dir_rows[i].y;
			r.player_angle = dir_rows[i].ang;
			issue(r, 1'b0);
			if (dir_rows[i].h0 >= 0 && column_q[column_q.size() - NRAYS].wall_height
					!= 9'(dir_rows[i].h0)) begin
				mismatches++;
				$display("directed row %0d: predictor height off", i);
			end
		end
		for (int i = 0; i < NRAND; i++) begin
			if (i % 30 == 0) begin
				start <= 1'b0;
				drain();
				case ($urandom_range(3))
					0: rand_map = {$urandom, $urandom};
					1: rand_map = 64'hFF81_8181_8181_81FF | ({$urandom, $urandom} &
						{$urandom, $urandom} & {$urandom, $urandom});
					2: rand_map = {$urandom, $urandom} & {$urandom, $urandom} &
						{$urandom, $urandom};
					default: rand_map = ~64'h0 ^ (64'h1 << $urandom_range(63));
				endcase
				load_map(rand_map);
			end
			n_open = $urandom_range(9);
			if (n_open < 7) begin
				// inside the map
				r.player_x = 13'($urandom_range(8191) & 13'h1FFF);
				r.player_y = 13'($urandom_range(8191));
			end else begin
				r.player_x = 13'($urandom);
				r.player_y = 13'($urandom);
			end
			r.player_angle = ($urandom_range(9) == 0) ? 9'($urandom) :
				9'($urandom_range(359));
			issue(r, i >= 60 && i < 120);
		end
		start <= 1'b0;
		fork
			while (column_q.size() != 0 || busy) @(posedge clk);
			begin
				#50000000;
				$display("grid_raycast_wall_columns_core verification failed");
				$finish;
			end
		join_any
		disable fork;
		repeat (50) @(posedge clk);
		$display("%0d frames, %0d columns checked (%0d full height, %0d no hit)",
			frames, columns_seen, full_height, empty_rays);
		if (mismatches == 0 && column_q.size() == 0)
			$display("grid_raycast_wall_columns_core verification clean");
		else
			$display("grid_raycast_wall_columns_core verification failed");
		$finish;
	end

	initial begin
		#400000000;
		$display("grid_raycast_wall_columns_core verification failed");
		$finish;
	end
endmodule
`default_nettype wire
